// ===== src/atrb_pkg.sv =====
// Shared types, constants and helpers of the adaptive timestamp reorder buffer.
// No dependencies; every other file imports this package.
package atrb_pkg;

  localparam int unsigned StampW  = 53;
  localparam int unsigned TagW    = 16;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned HoldW   = 26;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned QueueDepthDef = 32;
  localparam int unsigned HistDepthDef  = 16;
  localparam int unsigned FifoDepth     = 2;

  // Length of one jitter aggregation period in microseconds
  localparam logic [TimeW:0] AggregationUs = 49'd1000000;

  // Register reset values
  localparam logic [HoldW-1:0] InitHoldRst = 26'd200000;
  localparam logic [HoldW-1:0] MinHoldRst  = 26'd0;
  localparam logic [HoldW-1:0] MaxHoldRst  = 26'd5000000;
  localparam logic [HoldW-1:0] WindowRst   = 26'd10000000;
  localparam logic [HoldW-1:0] HoldRst     =
      (InitHoldRst > MinHoldRst) ? InitHoldRst : MinHoldRst;

  // Item modes
  localparam logic ModeInsert = 1'b0;
  localparam logic ModeFlush  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INIT_HOLD = 3'd0,
    REG_MIN_HOLD  = 3'd1,
    REG_MAX_HOLD  = 3'd2,
    REG_SHRINK    = 3'd3,
    REG_WINDOW    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              mode;
    logic [StampW-1:0] packet_stamp;
    logic [TagW-1:0]   packet_tag;
    logic [TimeW-1:0]  arrival_time_us;
  } in_item_t;

  typedef struct packed {
    logic [StampW-1:0] out_stamp;
    logic [TagW-1:0]   out_tag;
    logic              last_of_run;
    logic [HoldW-1:0]  hold_now_us;
  } out_item_t;

  typedef struct packed {
    logic [HoldW-1:0] init_hold;
    logic [HoldW-1:0] min_hold;
    logic [HoldW-1:0] max_hold;
    logic             shrink_en;
    logic [HoldW-1:0] window;
  } cfg_t;

  // Configuration write as seen by the jitter unit
  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [HoldW-1:0]   data;
  } cfg_wr_t;

  // Request and response between back-end control and jitter unit
  typedef struct packed {
    logic              start;
    logic [StampW-1:0] stamp;
    logic [TimeW-1:0]  now;
  } jit_req_t;

  typedef struct packed {
    logic             done;
    logic [HoldW-1:0] hold;
  } jit_rsp_t;

  // Command to the sorted queue
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [StampW-1:0] stamp;
    logic [TagW-1:0]   tag;
  } sort_cmd_t;

  // 1.5x rounded down: x + (x >> 1)
  function automatic logic [StampW:0] times_1p5(input logic [StampW-1:0] x);
    return {1'b0, x} + {2'b00, x[StampW-1:1]};
  endfunction

endpackage

// ===== src/atrb_fifo.sv =====
// Small first-in first-out queue used on the input and result sides.
// Depends on atrb_pkg for the default depth.
module atrb_fifo import atrb_pkg::*; #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = FifoDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Store the incoming transfer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== src/atrb_sorter.sv =====
// Timestamp-sorted queue built as a shift chain with per-cell compare.
// Depends on atrb_pkg for widths and the command struct.
module atrb_sorter import atrb_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sort_cmd_t                  cmd_i,
  output logic [$clog2(Depth+1)-1:0] fill_o,
  output logic [StampW-1:0]          front_stamp_o,
  output logic [TagW-1:0]            front_tag_o,
  output logic [StampW-1:0]          tail_stamp_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [StampW-1:0] stamp_q [Depth];
  logic [TagW-1:0]   tag_q   [Depth];
  logic [CntW-1:0]   fill_q;
  logic [StampW-1:0] tail_q;
  logic [Depth-1:0]  gt;

  assign fill_o        = fill_q;
  assign front_stamp_o = stamp_q[0];
  assign front_tag_o   = tag_q[0];
  assign tail_stamp_o  = tail_q;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic shift_in;

    // Occupied cells whose stamp lies above the new one move up one place
    assign gt[i] = (Idx < fill_q) && (stamp_q[i] > cmd_i.stamp);

    if (i > 0) begin : g_up
      assign shift_in = gt[i-1];
    end else begin : g_first
      assign shift_in = 1'b0;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins) begin
        if (shift_in) begin
          stamp_q[i] <= stamp_q[(i > 0) ? i - 1 : 0];
          tag_q[i]   <= tag_q[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (Idx == fill_q)) begin
          stamp_q[i] <= cmd_i.stamp;
          tag_q[i]   <= cmd_i.tag;
        end
      end else if (cmd_i.pop && (i < Depth - 1)) begin
        stamp_q[i] <= stamp_q[(i < Depth - 1) ? i + 1 : i];
        tag_q[i]   <= tag_q[(i < Depth - 1) ? i + 1 : i];
      end
    end
  end

  // Track fill level and the largest queued stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      tail_q <= '0;
    end else if (cmd_i.ins) begin
      fill_q <= fill_q + 1'b1;
      tail_q <= ((fill_q == '0) || (cmd_i.stamp > tail_q)) ? cmd_i.stamp : tail_q;
    end else if (cmd_i.pop) begin
      fill_q <= fill_q - 1'b1;
    end
  end

endmodule

// ===== src/atrb_jitter.sv =====
// Jitter tracker: configuration registers, newest stamp, windowed peak history
// and the adaptive hold duration. Depends on atrb_pkg.
module atrb_jitter import atrb_pkg::*; #(
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_wr_t  cfg_wr_i,
  input  jit_req_t req_i,
  output jit_rsp_t rsp_o
);

  localparam int unsigned HW = $clog2(HistDepth);
  localparam int unsigned FW = $clog2(HistDepth + 1);

  typedef enum logic [8:0] {
    J_IDLE      = 9'b000000001,
    J_CHK_LAST  = 9'b000000010,
    J_APPEND    = 9'b000000100,
    J_PRUNE_RD  = 9'b000001000,
    J_PRUNE_CHK = 9'b000010000,
    J_SCAN_RD   = 9'b000100000,
    J_SCAN_ACC  = 9'b001000000,
    J_GROW      = 9'b010000000,
    J_SHRINK    = 9'b100000000
  } jit_state_e;

  jit_state_e        state_q, state_d;
  cfg_t              cfg_q, cfg_d;
  logic              started_q;
  logic [HoldW-1:0]  hold_q, hold_d;
  logic [StampW-1:0] newest_q, newest_d;
  logic [HW-1:0]     head_q, head_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     idx_q, idx_d;
  logic              filled_q, filled_d;
  logic              done_q, done_d;
  logic [StampW-1:0] stamp_q, jit_q, peak_q, peak_d;
  logic [TimeW-1:0]  now_q;
  logic [StampW:0]   jit15_q, peak15_q;

  // History memory
  logic [TimeW-1:0]  hist_time [HistDepth];
  logic [StampW-1:0] hist_peak [HistDepth];
  logic [TimeW-1:0]  rd_time_q;
  logic [StampW-1:0] rd_peak_q;
  logic [HW-1:0]     rd_addr, wr_addr, last_idx;
  logic              wr_en;
  logic [TimeW-1:0]  wr_time;
  logic [StampW-1:0] wr_peak;

  logic [StampW-1:0] newest_new;

  function automatic logic [HW-1:0] wrap(input logic [HW:0] s);
    logic [HW:0] r;
    r = (s >= (HW+1)'(HistDepth)) ? s - (HW+1)'(HistDepth) : s;
    return r[HW-1:0];
  endfunction

  assign rsp_o.done = done_q;
  assign rsp_o.hold = hold_q;

  assign newest_new = (req_i.stamp > newest_q) ? req_i.stamp : newest_q;
  assign last_idx   = wrap({1'b0, head_q} + (HW+1)'(fill_q) - 1'b1);

  // Apply configuration writes; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_i.valid) begin
      unique case (cfg_wr_i.index)
        REG_INIT_HOLD: cfg_d.init_hold = cfg_wr_i.data;
        REG_MIN_HOLD:  cfg_d.min_hold  = cfg_wr_i.data;
        REG_MAX_HOLD:  cfg_d.max_hold  = cfg_wr_i.data;
        REG_SHRINK:    cfg_d.shrink_en = cfg_wr_i.data[0];
        REG_WINDOW:    cfg_d.window    = cfg_wr_i.data;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Sequence one hold update
  always_comb begin
    state_d  = state_q;
    hold_d   = hold_q;
    newest_d = newest_q;
    head_d   = head_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    filled_d = filled_q;
    peak_d   = peak_q;
    done_d   = 1'b0;
    rd_addr  = last_idx;
    wr_en    = 1'b0;
    wr_addr  = last_idx;
    wr_time  = now_q;
    wr_peak  = jit_q;

    unique case (state_q)
      J_IDLE: begin
        // reload start-up hold until the first packet
        if (cfg_wr_i.valid && !started_q &&
            (cfg_wr_i.index == REG_INIT_HOLD || cfg_wr_i.index == REG_MIN_HOLD)) begin
          hold_d = (cfg_d.init_hold > cfg_d.min_hold) ? cfg_d.init_hold : cfg_d.min_hold;
        end
        if (req_i.start) begin
          newest_d = newest_new;
          filled_d = 1'b0;
          peak_d   = '0;
          if (newest_new == req_i.stamp) begin
            done_d = 1'b1;
          end else if (fill_q != '0) begin
            state_d = J_CHK_LAST;
          end else begin
            state_d = J_APPEND;
          end
        end
      end
      J_CHK_LAST: begin
        // fold into the current period or open a new one
        if ({1'b0, now_q} < {1'b0, rd_time_q} + AggregationUs) begin
          wr_en   = 1'b1;
          wr_addr = last_idx;
          wr_time = rd_time_q;
          wr_peak = (jit_q > rd_peak_q) ? jit_q : rd_peak_q;
          state_d = J_PRUNE_RD;
        end else begin
          state_d = J_APPEND;
        end
      end
      J_APPEND: begin
        wr_en = 1'b1;
        if (fill_q == FW'(HistDepth)) begin
          wr_addr = head_q;
          head_d  = wrap({1'b0, head_q} + 1'b1);
        end else begin
          wr_addr = wrap({1'b0, head_q} + (HW+1)'(fill_q));
          fill_d  = fill_q + 1'b1;
        end
        state_d = J_PRUNE_RD;
      end
      J_PRUNE_RD: begin
        rd_addr = head_q;
        state_d = (fill_q == '0) ? J_GROW : J_PRUNE_CHK;
      end
      J_PRUNE_CHK: begin
        // drop entries that fell out of the window
        if ({1'b0, rd_time_q} + {{(TimeW+1-HoldW){1'b0}}, cfg_q.window} < {1'b0, now_q}) begin
          head_d   = wrap({1'b0, head_q} + 1'b1);
          fill_d   = fill_q - 1'b1;
          filled_d = 1'b1;
          state_d  = J_PRUNE_RD;
        end else begin
          idx_d   = '0;
          state_d = J_SCAN_RD;
        end
      end
      J_SCAN_RD: begin
        rd_addr = wrap({1'b0, head_q} + (HW+1)'(idx_q));
        state_d = J_SCAN_ACC;
      end
      J_SCAN_ACC: begin
        if (rd_peak_q > peak_q) peak_d = rd_peak_q;
        idx_d   = idx_q + 1'b1;
        state_d = (idx_q + 1'b1 == fill_q) ? J_GROW : J_SCAN_RD;
      end
      J_GROW: begin
        if ({1'b0, stamp_q} + {{(StampW+1-HoldW){1'b0}}, hold_q} < {1'b0, newest_q}) begin
          hold_d = (jit15_q > {{(StampW+1-HoldW){1'b0}}, cfg_q.max_hold}) ?
                   cfg_q.max_hold : jit15_q[HoldW-1:0];
        end
        state_d = J_SHRINK;
      end
      J_SHRINK: begin
        if (filled_q && cfg_q.shrink_en &&
            (peak15_q < {{(StampW+1-HoldW){1'b0}}, hold_q})) begin
          hold_d = (peak15_q[HoldW-1:0] > cfg_q.min_hold) ? peak15_q[HoldW-1:0]
                                                           : cfg_q.min_hold;
        end
        done_d  = 1'b1;
        state_d = J_IDLE;
      end
      default: state_d = J_IDLE;
    endcase
  end

  // History memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_time[wr_addr] <= wr_time;
      hist_peak[wr_addr] <= wr_peak;
    end
    rd_time_q <= hist_time[rd_addr];
    rd_peak_q <= hist_peak[rd_addr];
  end

  // Latch the request and the scaled values
  always_ff @(posedge clk_i) begin
    if (state_q == J_IDLE && req_i.start) begin
      stamp_q <= req_i.stamp;
      now_q   <= req_i.now;
      jit_q   <= newest_new - req_i.stamp;
    end
    peak_q   <= peak_d;
    jit15_q  <= times_1p5(jit_q);
    peak15_q <= times_1p5(peak_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= J_IDLE;
      cfg_q     <= '{init_hold: InitHoldRst, min_hold: MinHoldRst, max_hold: MaxHoldRst,
                     shrink_en: 1'b0, window: WindowRst};
      started_q <= 1'b0;
      hold_q    <= HoldRst;
      newest_q  <= '0;
      head_q    <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
      filled_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cfg_q    <= cfg_d;
      hold_q   <= hold_d;
      newest_q <= newest_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      filled_q <= filled_d;
      done_q   <= done_d;
      if (state_q == J_IDLE && req_i.start) started_q <= 1'b1;
    end
  end

endmodule

// ===== src/adaptive_timestamp_reorder_buffer.sv =====
// Adaptive timestamp reorder buffer: input queue, back-end control, jitter tracker, sorted queue, result queue.
// Depends on atrb_pkg, atrb_fifo, atrb_sorter and atrb_jitter.

// Every item is first taken from the input queue. A flush then emits every
// queued packet and closes the run. An insert runs the jitter tracker, which
// walks its history memory: it folds the jitter into the last entry or appends
// a new one, drops entries that fell out of the window, scans the entries left
// for the peak and then grows or shrinks the hold; it skips the walk when the
// packet does not lag the newest stamp. The block then evicts from a full
// queue, does the sorted insert, emits further packets and closes the run. Each
// emitted packet and the closing transfer wait while the result queue is full.
// Results leave through a two-entry queue and the input side buffers two items,
// so both sides may stall independently.
// Results of one input carry the hold duration in force after that input.
module adaptive_timestamp_reorder_buffer import atrb_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned HistDepth  = HistDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item_i,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HoldW-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef enum logic [6:0] {
    B_IDLE   = 7'b0000001,
    B_HOLD   = 7'b0000010,
    B_EVICT  = 7'b0000100,
    B_INSERT = 7'b0001000,
    B_DRAIN  = 7'b0010000,
    B_FLUSH  = 7'b0100000,
    B_FINISH = 7'b1000000
  } back_state_e;

  back_state_e       state_q, state_d;
  in_item_t          in_head;
  logic              in_empty, in_pop;
  logic              out_push, out_full;
  out_item_t         out_wdata;
  cfg_wr_t           cfg_wr;
  jit_req_t          jit_req;
  jit_rsp_t          jit_rsp;
  sort_cmd_t         sort_cmd;
  logic [CntW-1:0]   sort_fill;
  logic [StampW-1:0] front_stamp, tail_stamp;
  logic [TagW-1:0]   front_tag;
  logic [StampW-1:0] cur_stamp_q;
  logic [TagW-1:0]   cur_tag_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [StampW-1:0] pend_stamp_q;
  logic [TagW-1:0]   pend_tag_q;
  logic              can_emit, emit, drain_go;

  // Front: buffer incoming items
  atrb_fifo #(.item_t(in_item_t), .Depth(FifoDepth)) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item_i),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_head),
    .empty_o (in_empty)
  );

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  atrb_jitter #(.HistDepth(HistDepth)) u_jitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .req_i    (jit_req),
    .rsp_o    (jit_rsp)
  );

  atrb_sorter #(.Depth(QueueDepth)) u_sorter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (sort_cmd),
    .fill_o        (sort_fill),
    .front_stamp_o (front_stamp),
    .front_tag_o   (front_tag),
    .tail_stamp_o  (tail_stamp)
  );

  // Back: one emitted packet is held back until we know whether it ends the run
  assign can_emit = !pend_q || !out_full;
  assign drain_go = (sort_fill != '0) && (cnt_q != CntW'(QueueDepth)) &&
                    ({1'b0, front_stamp} + {{(StampW+1-HoldW){1'b0}}, jit_rsp.hold}
                     <= {1'b0, tail_stamp});

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    pend_d         = pend_q;
    in_pop         = 1'b0;
    emit           = 1'b0;
    out_push       = 1'b0;
    jit_req.start  = 1'b0;
    jit_req.stamp  = in_head.packet_stamp;
    jit_req.now    = in_head.arrival_time_us;
    sort_cmd.ins   = 1'b0;
    sort_cmd.pop   = 1'b0;
    sort_cmd.stamp = cur_stamp_q;
    sort_cmd.tag   = cur_tag_q;
    out_wdata.out_stamp   = pend_stamp_q;
    out_wdata.out_tag     = pend_tag_q;
    out_wdata.last_of_run = 1'b0;
    out_wdata.hold_now_us = jit_rsp.hold;

    unique case (state_q)
      B_IDLE: begin
        cnt_d = '0;
        if (!in_empty) begin
          in_pop = 1'b1;
          if (in_head.mode == ModeFlush) begin
            state_d = B_FLUSH;
          end else begin
            jit_req.start = 1'b1;
            state_d       = B_HOLD;
          end
        end
      end
      B_HOLD: begin
        if (jit_rsp.done) begin
          state_d = (sort_fill == CntW'(QueueDepth)) ? B_EVICT : B_INSERT;
        end
      end
      B_EVICT: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = B_INSERT;
        end
      end
      B_INSERT: begin
        sort_cmd.ins = 1'b1;
        state_d      = B_DRAIN;
      end
      B_DRAIN: begin
        if (!drain_go) begin
          state_d = B_FINISH;
        end else if (can_emit) begin
          emit = 1'b1;
        end
      end
      B_FLUSH: begin
        if (sort_fill == '0) begin
          state_d = B_FINISH;
        end else if (can_emit) begin
          emit = 1'b1;
        end
      end
      B_FINISH: begin
        // close the run on the held-back packet
        if (!pend_q) begin
          state_d = B_IDLE;
        end else if (!out_full) begin
          out_push              = 1'b1;
          out_wdata.last_of_run = 1'b1;
          pend_d                = 1'b0;
          state_d               = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (emit) begin
      sort_cmd.pop = 1'b1;
      cnt_d        = cnt_q + 1'b1;
      out_push     = pend_q;
      pend_d       = 1'b1;
    end
  end

  atrb_fifo #(.item_t(out_item_t), .Depth(FifoDepth)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  // Hold the current packet and the held-back result
  always_ff @(posedge clk_i) begin
    if (in_pop) begin
      cur_stamp_q <= in_head.packet_stamp;
      cur_tag_q   <= in_head.packet_tag;
    end
    if (emit) begin
      pend_stamp_q <= front_stamp;
      pend_tag_q   <= front_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full) else $error("result pushed into full queue");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_cmd.ins |-> (sort_fill != CntW'(QueueDepth))) else $error("insert into full queue");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jit_rsp.done |-> (state_q == B_HOLD)) else $error("hold update done while not waiting");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE) |-> !pend_q) else $error("run left a result held back");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for adaptive_timestamp_reorder_buffer.
// Drives inserts and flushes with random gaps, predicts the sorted output and
// the adaptive hold duration in-house, and compares every result. Uses atrb_pkg.
`timescale 1ns / 100ps

module testbench;
  import atrb_pkg::*;

  localparam int unsigned QDepth   = 32;
  localparam int unsigned HDepth   = 16;
  localparam longint unsigned AggUs = 64'd1000000;
  localparam int unsigned CycleLimit = 1200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [HoldW-1:0] cfg_data_i = '0;

  adaptive_timestamp_reorder_buffer dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  longint unsigned init_hold, min_hold, max_hold, win_us;
  bit shrink_on, started;
  longint unsigned q_stamp[$];
  logic [TagW-1:0] q_tag[$];
  longint unsigned newest, hold;
  longint unsigned h_time[HDepth];
  longint unsigned h_peak[HDepth];
  int unsigned h_fill, h_head;

  out_item_t pending_results[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned stall_hold = 0;
  bit long_stall_done = 0;
  bit stall_req = 0;

  function automatic longint unsigned x1p5(longint unsigned x);
    return x + (x >> 1);
  endfunction

  function automatic void reset_model();
    init_hold = 200000; min_hold = 0; max_hold = 5000000;
    shrink_on = 0; win_us = 10000000; started = 0;
    q_stamp.delete(); q_tag.delete();
    newest = 0; h_fill = 0; h_head = 0;
    hold = 200000;
  endfunction

  function automatic void track_jitter(longint unsigned stamp, longint unsigned now);
    longint unsigned jit, pk, grown;
    int unsigned last, slot;
    bit filled, merged;
    filled = 0;
    merged = 0;
    if (stamp > newest) newest = stamp;
    jit = newest - stamp;
    if (jit == 0) return;
    // merge into the current aggregation period or open a new one
    if (h_fill > 0) begin
      last = (h_head + h_fill - 1) % HDepth;
      if (now < h_time[last] + AggUs) begin
        if (jit > h_peak[last]) h_peak[last] = jit;
        merged = 1;
      end
    end
    if (!merged) begin
      if (h_fill >= HDepth) begin
        h_head = (h_head + 1) % HDepth;
        h_fill--;
      end
      slot = (h_head + h_fill) % HDepth;
      h_time[slot] = now;
      h_peak[slot] = jit;
      h_fill++;
    end
    // drop entries outside the window
    while (h_fill > 0 && h_time[h_head] + win_us < now) begin
      h_head = (h_head + 1) % HDepth;
      h_fill--;
      filled = 1;
    end
    pk = 0;
    for (int i = 0; i < h_fill; i++)
      if (h_peak[(h_head + i) % HDepth] > pk) pk = h_peak[(h_head + i) % HDepth];
    if (stamp + hold < newest) begin
      grown = x1p5(jit);
      hold = (grown > max_hold) ? max_hold : grown;
    end
    if (filled && shrink_on && x1p5(pk) < hold)
      hold = (x1p5(pk) > min_hold) ? x1p5(pk) : min_hold;
  endfunction

  function automatic void emit_oldest(ref out_item_t run[$]);
    out_item_t r;
    r = '0;
    r.out_stamp = q_stamp[0][StampW-1:0];
    r.out_tag = q_tag[0];
    q_stamp.delete(0);
    q_tag.delete(0);
    run.insert(run.size(), r);
  endfunction

  // Compute the results of one input and append them to the expected store
  function automatic void predict_release(in_item_t it);
    out_item_t run[$];
    int pos;
    if (it.mode == ModeFlush) begin
      while (q_stamp.size() > 0) emit_oldest(run);
    end else begin
      started = 1;
      track_jitter(it.packet_stamp, it.arrival_time_us);
      if (q_stamp.size() >= QDepth) emit_oldest(run);
      pos = q_stamp.size();
      while (pos > 0 && q_stamp[pos-1] > it.packet_stamp) pos--;
      q_stamp.insert(pos, it.packet_stamp);
      q_tag.insert(pos, it.packet_tag);
      while (q_stamp.size() > 0 && run.size() < QDepth &&
             q_stamp[0] + hold <= q_stamp[q_stamp.size()-1])
        emit_oldest(run);
    end
    foreach (run[k]) begin
      run[k].hold_now_us = hold[HoldW-1:0];
      run[k].last_of_run = (k == run.size() - 1);
      pending_results.insert(pending_results.size(), run[k]);
    end
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random pop with one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: %p", $time, out_item_o);
          errors++;
        end else begin
          out_item_t exp_r;
          exp_r = pending_results[0];
          pending_results.delete(0);
          if (out_item_o.out_stamp !== exp_r.out_stamp)
            $display("%0t out_stamp exp %0d got %0d", $time, exp_r.out_stamp,
                     out_item_o.out_stamp);
          if (out_item_o.out_tag !== exp_r.out_tag)
            $display("%0t out_tag exp %0h got %0h", $time, exp_r.out_tag,
                     out_item_o.out_tag);
          if (out_item_o.last_of_run !== exp_r.last_of_run)
            $display("%0t last_of_run exp %0b got %0b", $time, exp_r.last_of_run,
                     out_item_o.last_of_run);
          if (out_item_o.hold_now_us !== exp_r.hold_now_us)
            $display("%0t hold_now_us exp %0d got %0d", $time, exp_r.hold_now_us,
                     out_item_o.hold_now_us);
          if (out_item_o !== exp_r) errors++;
        end
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        pop <= 1'b0;
      end else if (!long_stall_done && stall_req) begin
        long_stall_done <= 1;
        stall_hold <= 600;
        pop <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
        pop <= 1'b0;
        stall_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : 0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until transferred; push stays high for the next one
  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_release(it);
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(cfg_reg_e idx, longint unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[HoldW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_INIT_HOLD: init_hold = val[HoldW-1:0];
      REG_MIN_HOLD:  min_hold = val[HoldW-1:0];
      REG_MAX_HOLD:  max_hold = val[HoldW-1:0];
      REG_SHRINK:    shrink_on = val[0];
      REG_WINDOW:    win_us = val[HoldW-1:0];
      default: ;
    endcase
    if (!started && (idx == REG_INIT_HOLD || idx == REG_MIN_HOLD))
      hold = (init_hold > min_hold) ? init_hold : min_hold;
  endtask

  // Drop push and wait until the block is idle again
  task automatic drain_wait();
    push <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic in_item_t mk(bit m, longint unsigned s, int unsigned t,
                                  longint unsigned a);
    in_item_t it;
    it.mode = m;
    it.packet_stamp = s[StampW-1:0];
    it.packet_tag = t[TagW-1:0];
    it.arrival_time_us = a[TimeW-1:0];
    return it;
  endfunction

  // Directed rows; where given, the stamp of the last predicted result is checked right away
  typedef struct {
    in_item_t it;
    bit has_exp;
    longint unsigned exp_stamp;
  } stim_row_t;

  localparam longint unsigned SMax = 64'h1F_FFFF_FFFF_FFFF;
  localparam longint unsigned TMax = 64'hFFFF_FFFF_FFFF;

  stim_row_t rows[$];
  longint unsigned base_stamp, wall;

  function automatic void add_row(in_item_t it, bit has_exp, longint unsigned exp_stamp);
    stim_row_t row;
    row.it = it;
    row.has_exp = has_exp;
    row.exp_stamp = exp_stamp;
    rows.insert(rows.size(), row);
  endfunction

  initial begin
    int unsigned n;
    in_item_t it;
    longint unsigned got_stamp;
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings
    add_row(mk(ModeFlush, 0, 0, 0), 0, 0);              // flush of empty queue
    add_row(mk(ModeInsert, 0, 16'h0000, 0), 0, 0);
    add_row(mk(ModeInsert, 0, 16'hFFFF, 0), 0, 0);      // equal stamps tie
    add_row(mk(ModeInsert, 150000, 16'h1234, 10), 0, 0);
    add_row(mk(ModeInsert, 200000, 16'h2222, 20), 1, 0); // oldest at hold edge
    add_row(mk(ModeInsert, 100, 16'h3333, 30), 0, 0);    // lags the newest stamp
    add_row(mk(ModeInsert, 50, 16'h4444, 2000000), 0, 0);
    add_row(mk(ModeInsert, 60, 16'h5555, 1000), 0, 0);   // arrival backwards
    add_row(mk(ModeFlush, SMax, 16'hFFFF, TMax), 0, 0);
    add_row(mk(ModeInsert, SMax, 16'hAAAA, TMax), 0, 0); // extremes
    add_row(mk(ModeInsert, SMax - 1, 16'h5555, TMax), 0, 0);
    add_row(mk(ModeFlush, 0, 0, 0), 1, SMax);
    foreach (rows[r]) begin
      send_item(rows[r].it);
      if (rows[r].has_exp) begin
        got_stamp = (pending_results.size() > 0) ?
                    pending_results[pending_results.size()-1].out_stamp : 0;
        if (pending_results.size() == 0 || got_stamp != rows[r].exp_stamp) begin
          $display("%0t directed row %0d exp %0d got %0d", $time, r, rows[r].exp_stamp,
                   got_stamp);
          errors++;
        end
      end
    end
    drain_wait();

    // Five phases of settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MAX_HOLD, 26'h3FF_FFFF); write_reg(REG_SHRINK, 1);
          write_reg(REG_WINDOW, 1000000); write_reg(REG_MIN_HOLD, 0);
          write_reg(REG_INIT_HOLD, 0);
        end
        1: begin
          write_reg(REG_MIN_HOLD, 26'h3FF_FFFF); write_reg(REG_MAX_HOLD, 0);
          write_reg(REG_WINDOW, 26'h3FF_FFFF); write_reg(REG_SHRINK, 0);
        end
        2: begin
          write_reg(REG_MIN_HOLD, 20000); write_reg(REG_MAX_HOLD, 3000000);
          write_reg(REG_WINDOW, 2500000); write_reg(REG_SHRINK, 1);
          write_reg(REG_INIT_HOLD, 26'h3FF_FFFF);
        end
        3: begin
          write_reg(REG_MIN_HOLD, 0); write_reg(REG_MAX_HOLD, 400000);
          write_reg(REG_WINDOW, 1500000);
        end
        default: begin
          write_reg(REG_INIT_HOLD, 100000); write_reg(REG_SHRINK, 0);
          write_reg(REG_MAX_HOLD, 5000000); write_reg(REG_WINDOW, 10000000);
        end
      endcase
      cfg_valid_i <= 1'b0;
      // hold off the result side for a long stretch while items keep coming
      if (ph == 1) stall_req = 1;
      // flush any leftovers and restart the stream
      send_item(mk(ModeFlush, 0, 0, 0));
      base_stamp = {$urandom, $urandom} & SMax;
      if (ph == 0) base_stamp = 1000;
      base_stamp = base_stamp & 64'h0F_FFFF_FFFF_FFFF;
      wall = {$urandom_range(0, 65535), $urandom} & 64'h7FFF_FFFF_FFFF;
      n = (ph == 4) ? 40 : 45;
      for (int k = 0; k < n; k++) begin
        int unsigned sel;
        sel = $urandom_range(0, 99);
        wall += $urandom_range(0, 400000);
        if (sel < 70) begin
          // well-formed stream with random jitter on some stamps
          base_stamp += $urandom_range(0, 60000);
          it = mk(ModeInsert, base_stamp - $urandom_range(0, 300000) * ($urandom_range(0, 2) == 0),
                  $urandom, wall);
        end else if (sel < 80) begin
          it = mk(ModeInsert, base_stamp - $urandom_range(0, 5000000), $urandom, wall);
        end else if (sel < 92) begin
          it = mk(ModeInsert, {$urandom, $urandom} & SMax, $urandom,
                  ($urandom_range(0, 1) ? wall : {$urandom, $urandom} & TMax));
        end else begin
          it = mk(ModeFlush, {$urandom, $urandom} & SMax, $urandom, {$urandom, $urandom} & TMax);
        end
        send_item(it);
      end
      drain_wait();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== adaptive_timestamp_reorder_buffer.f =====
src/atrb_pkg.sv
src/atrb_fifo.sv
src/atrb_sorter.sv
src/atrb_jitter.sv
src/adaptive_timestamp_reorder_buffer.sv
verif/testbench.sv
